### hw/rtl/elv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package elv_pkg;

	// Car geometry and field widths
	localparam int unsigned FLOORS    = 3;
	localparam int unsigned FLOOR_W   = 2;
	localparam int unsigned TICK_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAIT_TICKS  = 2'd0,
		REG_DOOR_TICKS  = 2'd1,
		REG_FLOOR_TICKS = 2'd2
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [TICK_W-1:0] WAIT_TICKS_RST  = 8'd2;
	localparam logic [TICK_W-1:0] DOOR_TICKS_RST  = 8'd6;
	localparam logic [TICK_W-1:0] FLOOR_TICKS_RST = 8'd16;

	// Input operation codes
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_CALL = 1'b1
	} op_t;

	// Car modes
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_WAIT  = 3'd1,
		MODE_CLOSE = 3'd2,
		MODE_MOVE  = 3'd3,
		MODE_OPEN  = 3'd4
	} mode_t;

	typedef struct packed {
		logic               op;
		logic [FLOOR_W-1:0] call_floor;
	} in_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] floor_now;
		logic [2:0]         mode_code;
		logic               red_lamp;
		logic               yellow_lamp;
		logic               green_lamp;
		logic [FLOOR_W-1:0] shown_digit;
		logic               shown_dash;
		logic               ticking;
	} out_t;

	typedef struct packed {
		logic [TICK_W-1:0] wait_ticks;
		logic [TICK_W-1:0] door_ticks;
		logic [TICK_W-1:0] floor_ticks;
	} cfg_t;

	typedef struct packed {
		logic green;
		logic yellow;
		logic red;
	} lamps_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] car_floor;
		logic [FLOOR_W-1:0] target_floor;
		mode_t              mode;
		logic [TICK_W-1:0]  move_count;
		logic [TICK_W-1:0]  wait_count;
		logic [TICK_W-1:0]  close_count;
		logic [TICK_W-1:0]  open_count;
		lamps_t             lamps;
		logic               timer_on;
		logic [FLOOR_W-1:0] display_digit;
		logic               display_dash;
	} state_t;

	typedef struct packed {
		logic              wrap;
		logic [TICK_W-1:0] cnt;
	} count_step_t;

	// Advance a wrapping phase counter; a length of zero wraps on every tick
	function automatic count_step_t count_advance(input logic [TICK_W-1:0] cnt,
			input logic [TICK_W-1:0] len);
		logic [TICK_W:0] nxt;
		count_step_t     res;
		nxt = {1'b0, cnt} + {{TICK_W{1'b0}}, 1'b1};
		if (nxt >= {1'b0, len}) begin
			res.wrap = 1'b1;
			res.cnt  = '0;
		end else begin
			res.wrap = 1'b0;
			res.cnt  = nxt[TICK_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/elv_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module elv_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [elv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [elv_pkg::TICK_W-1:0]    cfg_data,
	output elv_pkg::cfg_t                      cfg
);
	import elv_pkg::*;

	cfg_t cfg_q;

	// Write the addressed phase length; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_ticks  <= WAIT_TICKS_RST;
			cfg_q.door_ticks  <= DOOR_TICKS_RST;
			cfg_q.floor_ticks <= FLOOR_TICKS_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_WAIT_TICKS:  cfg_q.wait_ticks  <= cfg_data;
				REG_DOOR_TICKS:  cfg_q.door_ticks  <= cfg_data;
				REG_FLOOR_TICKS: cfg_q.floor_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/elv_core.sv
`timescale 1ns / 1ps
`default_nettype none

module elv_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   step_en,
	input  wire elv_pkg::in_t  item,
	input  wire elv_pkg::cfg_t cfg,
	output elv_pkg::out_t result
);
	import elv_pkg::*;

	state_t      st_q;
	state_t      st_nxt;
	count_step_t cs;

	// Next state for one beat
	always_comb begin
		st_nxt = st_q;
		cs     = '0;
		if (item.op == OP_CALL) begin
			if (st_q.mode == MODE_IDLE && {30'd0, item.call_floor} < FLOORS) begin
				st_nxt.target_floor = item.call_floor;
				if (item.call_floor != st_q.car_floor) begin
					st_nxt.mode     = MODE_WAIT;
					st_nxt.timer_on = 1'b1;
				end
			end
		end else if (st_q.timer_on) begin
			case (st_q.mode)
				MODE_MOVE: begin
					cs = count_advance(st_q.move_count, cfg.floor_ticks);
					st_nxt.move_count = cs.cnt;
					st_nxt.lamps.red  = ~st_q.lamps.red;
					if (cs.wrap && st_q.target_floor > st_q.car_floor) begin
						st_nxt.car_floor     = FLOOR_W'(st_q.car_floor + 1'b1);
						st_nxt.display_digit = FLOOR_W'(st_q.car_floor + 1'b1);
						st_nxt.display_dash  = 1'b0;
					end else if (cs.wrap && st_q.target_floor < st_q.car_floor) begin
						st_nxt.car_floor     = FLOOR_W'(st_q.car_floor - 1'b1);
						st_nxt.display_digit = FLOOR_W'(st_q.car_floor - 1'b1);
						st_nxt.display_dash  = 1'b0;
					end else if (st_q.target_floor == st_q.car_floor) begin
						st_nxt.mode      = MODE_OPEN;
						st_nxt.lamps.red = 1'b0;
					end else begin
						st_nxt.display_digit = (st_q.target_floor > st_q.car_floor) ?
							st_q.car_floor : FLOOR_W'(st_q.car_floor - 1'b1);
						st_nxt.display_dash  = 1'b1;
					end
				end
				MODE_WAIT: begin
					cs = count_advance(st_q.wait_count, cfg.wait_ticks);
					st_nxt.wait_count = cs.cnt;
					if (cs.wrap) begin
						st_nxt.mode = MODE_CLOSE;
					end
				end
				MODE_CLOSE: begin
					cs = count_advance(st_q.close_count, cfg.door_ticks);
					st_nxt.close_count   = cs.cnt;
					st_nxt.lamps.yellow  = cs.wrap ? 1'b0 : ~st_q.lamps.yellow;
					st_nxt.display_digit = st_q.car_floor;
					st_nxt.display_dash  = 1'b0;
					if (cs.wrap) begin
						st_nxt.mode = MODE_MOVE;
					end
				end
				MODE_OPEN: begin
					cs = count_advance(st_q.open_count, cfg.door_ticks);
					st_nxt.open_count    = cs.cnt;
					st_nxt.lamps.green   = cs.wrap ? 1'b0 : ~st_q.lamps.green;
					st_nxt.display_digit = st_q.car_floor;
					st_nxt.display_dash  = 1'b0;
					if (cs.wrap) begin
						st_nxt.mode = MODE_IDLE;
					end
				end
				default: begin
					st_nxt.lamps    = '0;
					st_nxt.timer_on = 1'b0;
				end
			endcase
		end
	end

	// Hold the car state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{
				car_floor:     '0,
				target_floor:  '0,
				mode:          MODE_IDLE,
				move_count:    '0,
				wait_count:    '0,
				close_count:   '0,
				open_count:    '0,
				lamps:         '0,
				timer_on:      1'b0,
				display_digit: '0,
				display_dash:  1'b0
			};
		end else if (step_en) begin
			st_q <= st_nxt;
		end
	end

	// Result shows the state after the beat
	always_comb begin
		result.floor_now   = st_nxt.car_floor;
		result.mode_code   = st_nxt.mode;
		result.red_lamp    = st_nxt.lamps.red;
		result.yellow_lamp = st_nxt.lamps.yellow;
		result.green_lamp  = st_nxt.lamps.green;
		result.shown_digit = st_nxt.display_digit;
		result.shown_dash  = st_nxt.display_dash;
		result.ticking     = st_nxt.timer_on;
	end

`ifndef NO_ASSERTIONS
	a_floor_range: assert property (@(posedge clk) disable iff (!arst_n)
		{30'd0, st_q.car_floor} < FLOORS)
		else $error("car floor out of range");
	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.timer_on |-> st_q.mode == MODE_IDLE)
		else $error("car active with the timer stopped");
	a_one_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(st_q.lamps))
		else $error("more than one lamp lit");
	a_red_moving: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.lamps.red |-> st_q.mode == MODE_MOVE)
		else $error("red lamp lit outside moving");
`endif

endmodule

`default_nettype wire

### hw/rtl/elevator_controller.sv
// Elevator controller: one result beat for every input beat.
// Input channel in_valid/in_ready/in_data carries either a timer tick or a
// floor call; output channel out_valid/out_ready/out_data returns the car
// state after that beat (floor, mode, lamps, display, timer flag).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// wait, door and floor tick lengths; cfg_ready is always high and writes
// are meant to arrive while no beat is in flight.
// A beat accepted into the input register is evaluated against the car state
// and lands in the output register once the output side can advance, from
// where it can be taken. The car takes one beat per cycle while out_ready
// keeps the output side moving; the state update between the input register
// and the output register is combinational.
// When out_ready is low the output register holds its beat, the input
// register fills, and in_ready drops once both are full; no beat is lost.
// Reset (arst_n low) puts the car idle at floor 0 with lamps off, the timer
// stopped, both registers empty, and the tick lengths at 2, 6 and 16.
`timescale 1ns / 1ps
`default_nettype none

module elevator_controller (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire elv_pkg::in_t                  in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output elv_pkg::out_t                      out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [elv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [elv_pkg::TICK_W-1:0]    cfg_data
);
	import elv_pkg::*;

	logic  valid_s1;
	in_t   item_s1;
	logic  out_valid_q;
	out_t  out_q;
	logic  advance;
	logic  step_en;
	cfg_t  cfg;
	out_t  result;

	assign advance   = !out_valid_q || out_ready;
	assign step_en   = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	elv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	elv_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Input register: take a beat whenever the slot frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Output register: load on a step, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled beat");
	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid_q)
		else $error("evaluated beat did not reach the output register");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import elv_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int N_PHASES   = 10;
	localparam int PHASE_MOVES = 140;

	// Status words that follow directly from the reset state
	localparam out_t AT_REST    = '0;
	localparam out_t WAITING0   = '{2'd0, MODE_WAIT, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 1'b1};
	localparam out_t CLOSING0   = '{2'd0, MODE_CLOSE, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 1'b1};
	localparam out_t CLOSING0_Y = '{2'd0, MODE_CLOSE, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0, 1'b1};
	localparam out_t MOVING0    = '{2'd0, MODE_MOVE, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 1'b1};

	typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		in_t                  beat;
		bit                   typed;
		out_t                 want;
		logic [CFG_IDX_W-1:0] idx;
		logic [TICK_W-1:0]    val;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	// Car model state and tick lengths
	logic [FLOOR_W-1:0] car_at;
	logic [FLOOR_W-1:0] car_goal;
	mode_t              car_mode;
	logic [TICK_W-1:0]  move_cnt;
	logic [TICK_W-1:0]  wait_cnt;
	logic [TICK_W-1:0]  close_cnt;
	logic [TICK_W-1:0]  open_cnt;
	lamps_t             lamp_on;
	logic               timer_run;
	logic [FLOOR_W-1:0] disp_digit;
	logic               disp_dash;
	logic [TICK_W-1:0]  len_wait;
	logic [TICK_W-1:0]  len_door;
	logic [TICK_W-1:0]  len_floor;

	out_t pending_status[$];
	int   fault_count;
	int   status_seen;

	elevator_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Advance a phase counter; report the wrap
	function automatic bit bump(inout logic [TICK_W-1:0] cnt, input logic [TICK_W-1:0] len);
		logic [TICK_W:0] nxt;
		nxt = {1'b0, cnt} + 1'b1;
		if (nxt >= {1'b0, len}) begin
			cnt = '0;
			return 1'b1;
		end
		cnt = nxt[TICK_W-1:0];
		return 1'b0;
	endfunction

	function automatic void car_reset();
		car_at     = '0;
		car_goal   = '0;
		car_mode   = MODE_IDLE;
		move_cnt   = '0;
		wait_cnt   = '0;
		close_cnt  = '0;
		open_cnt   = '0;
		lamp_on    = '0;
		timer_run  = 1'b0;
		disp_digit = '0;
		disp_dash  = 1'b0;
		len_wait   = WAIT_TICKS_RST;
		len_door   = DOOR_TICKS_RST;
		len_floor  = FLOOR_TICKS_RST;
	endfunction

	// Apply one beat to the car and return the status it leaves behind
	function automatic out_t car_step(input in_t beat);
		bit   wrap;
		out_t res;
		if (beat.op == OP_CALL) begin
			if (car_mode == MODE_IDLE && beat.call_floor < FLOORS) begin
				car_goal = beat.call_floor;
				if (car_goal != car_at) begin
					car_mode  = MODE_WAIT;
					timer_run = 1'b1;
				end
			end
		end else if (timer_run) begin
			case (car_mode)
				MODE_MOVE: begin
					wrap = bump(move_cnt, len_floor);
					lamp_on.red = ~lamp_on.red;
					if (wrap && car_goal > car_at) begin
						car_at     = car_at + 1'b1;
						disp_digit = car_at;
						disp_dash  = 1'b0;
					end else if (wrap && car_goal < car_at) begin
						car_at     = car_at - 1'b1;
						disp_digit = car_at;
						disp_dash  = 1'b0;
					end else if (car_goal == car_at) begin
						car_mode    = MODE_OPEN;
						lamp_on.red = 1'b0;
					end else begin
						// between floors: dash next to the lower floor
						disp_digit = (car_goal > car_at) ? car_at : car_at - 1'b1;
						disp_dash  = 1'b1;
					end
				end
				MODE_WAIT: begin
					if (bump(wait_cnt, len_wait))
						car_mode = MODE_CLOSE;
				end
				MODE_CLOSE: begin
					lamp_on.yellow = ~lamp_on.yellow;
					if (bump(close_cnt, len_door)) begin
						lamp_on.yellow = 1'b0;
						car_mode       = MODE_MOVE;
					end
					disp_digit = car_at;
					disp_dash  = 1'b0;
				end
				MODE_OPEN: begin
					lamp_on.green = ~lamp_on.green;
					if (bump(open_cnt, len_door)) begin
						lamp_on.green = 1'b0;
						car_mode      = MODE_IDLE;
					end
					disp_digit = car_at;
					disp_dash  = 1'b0;
				end
				default: begin
					lamp_on   = '0;
					timer_run = 1'b0;
				end
			endcase
		end
		res.floor_now   = car_at;
		res.mode_code   = car_mode;
		res.red_lamp    = lamp_on.red;
		res.yellow_lamp = lamp_on.yellow;
		res.green_lamp  = lamp_on.green;
		res.shown_digit = disp_digit;
		res.shown_dash  = disp_dash;
		res.ticking     = timer_run;
		return res;
	endfunction

	// A beat that changes something in the car, as opposed to one it drops
	function automatic bit takes_effect(input in_t beat);
		if (beat.op == OP_CALL)
			return car_mode == MODE_IDLE && beat.call_floor < FLOORS;
		return timer_run;
	endfunction

	// Mostly complete trips: call when idle, tick otherwise, with some noise
	function automatic in_t pick_beat();
		in_t beat;
		int  r;
		r = $urandom_range(0, 99);
		beat.call_floor = 2'($urandom_range(0, 3));
		if (car_mode == MODE_IDLE) begin
			beat.op = OP_CALL;
			if (r < 70)
				beat.call_floor = 2'((int'(car_at) + $urandom_range(1, FLOORS - 1)) % FLOORS);
			else if (r < 80)
				beat.call_floor = car_at;
			else if (r < 88)
				beat.call_floor = 2'($urandom_range(FLOORS, 3));
			else
				beat.op = OP_TICK;
		end else begin
			beat.op = (r < 88) ? OP_TICK : OP_CALL;
		end
		return beat;
	endfunction

	// Idle cycles: mostly none, some short, a few long
	function automatic int pause_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic script_row_t beat_row(input op_t op, input logic [FLOOR_W-1:0] fl);
		script_row_t row;
		row.kind            = ROW_BEAT;
		row.beat.op         = op;
		row.beat.call_floor = fl;
		row.typed           = 1'b0;
		row.want            = '0;
		row.idx             = '0;
		row.val             = '0;
		return row;
	endfunction

	function automatic script_row_t typed_row(input op_t op, input logic [FLOOR_W-1:0] fl,
			input out_t want);
		script_row_t row;
		row       = beat_row(op, fl);
		row.typed = 1'b1;
		row.want  = want;
		return row;
	endfunction

	function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [TICK_W-1:0] val);
		script_row_t row;
		row.kind  = ROW_WRITE;
		row.beat  = '0;
		row.typed = 1'b0;
		row.want  = '0;
		row.idx   = idx;
		row.val   = val;
		return row;
	endfunction

	function automatic void field_check(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endfunction

	// Hold the beat until taken, then record what the car should report
	task automatic push_beat(input in_t beat, input bit calm, input bit typed, input out_t want);
		int   gap;
		out_t pred;
		gap = pause_len(calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		pred = car_step(beat);
		pending_status.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WAIT_TICKS:  len_wait  = val;
			REG_DOOR_TICKS:  len_door  = val;
			REG_FLOOR_TICKS: len_floor = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait for every pending status beat, then let the pipeline empty
	task automatic settle();
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Compare each status beat with the oldest prediction
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			status_seen++;
			if (pending_status.size() == 0) begin
				$error("status beat with nothing pending: %h", out_data);
				fault_count++;
			end else begin
				want = pending_status.pop_front();
				field_check("floor_now", want.floor_now, out_data.floor_now);
				field_check("mode_code", want.mode_code, out_data.mode_code);
				field_check("red_lamp", want.red_lamp, out_data.red_lamp);
				field_check("yellow_lamp", want.yellow_lamp, out_data.yellow_lamp);
				field_check("green_lamp", want.green_lamp, out_data.green_lamp);
				field_check("shown_digit", want.shown_digit, out_data.shown_digit);
				field_check("shown_dash", want.shown_dash, out_data.shown_dash);
				field_check("ticking", want.ticking, out_data.ticking);
			end
		end
	end

	// Output side: random stalls, one long hold-off to back up the input
	initial begin
		int hold;
		bit squeezed;
		hold      = 0;
		squeezed  = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold == 0 && !squeezed && status_seen >= 300) begin
				hold     = 60;
				squeezed = 1'b1;
			end else if (hold == 0) begin
				hold = pause_len(((status_seen / 150) % 4) == 1);
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		script_row_t        script[$];
		logic [TICK_W-1:0]  plan[7][3];
		in_t                beat;
		int                 moved;

		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		fault_count = 0;
		status_seen = 0;
		arst_n      = 1'b0;
		car_reset();

		// wait, door, floor lengths per phase; later phases draw their own
		plan = '{'{8'd2, 8'd6, 8'd16}, '{8'd1, 8'd1, 8'd1}, '{8'd0, 8'd0, 8'd0},
			'{8'd3, 8'd255, 8'd4}, '{8'd1, 8'd2, 8'd255}, '{8'd255, 8'd1, 8'd1},
			'{8'd2, 8'd3, 8'd2}};

		// Reset state, dropped beats, a trip up, then a lowered length mid-phase
		script = '{
			typed_row(OP_TICK, 2'd0, AT_REST),
			typed_row(OP_CALL, 2'd3, AT_REST),
			typed_row(OP_CALL, 2'd0, AT_REST),
			typed_row(OP_CALL, 2'd2, WAITING0),
			typed_row(OP_CALL, 2'd1, WAITING0),
			typed_row(OP_TICK, 2'd0, WAITING0),
			typed_row(OP_TICK, 2'd0, CLOSING0),
			typed_row(OP_TICK, 2'd0, CLOSING0_Y),
			write_row(REG_DOOR_TICKS, 8'd0),
			typed_row(OP_TICK, 2'd0, MOVING0),
			write_row(REG_FLOOR_TICKS, 8'd1),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_CALL, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			write_row(REG_FLOOR_TICKS, 8'd255),
			write_row(REG_WAIT_TICKS, 8'd1),
			beat_row(OP_CALL, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			write_row(REG_FLOOR_TICKS, 8'd1),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_TICK, 2'd0),
			beat_row(OP_CALL, 2'd1)
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed rows
		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				in_valid <= 1'b0;
				settle();
				cfg_write(script[i].idx, script[i].val);
			end else begin
				push_beat(script[i].beat, 1'b0, script[i].typed, script[i].want);
			end
		end

		// Random trips under a new set of lengths each phase
		for (int p = 0; p < N_PHASES; p++) begin
			in_valid <= 1'b0;
			settle();
			if (p == 1)
				cfg_write(REG_SPARE, 8'($urandom));
			if (p < 7) begin
				cfg_write(REG_WAIT_TICKS, plan[p][0]);
				cfg_write(REG_DOOR_TICKS, plan[p][1]);
				cfg_write(REG_FLOOR_TICKS, plan[p][2]);
			end else begin
				cfg_write(REG_WAIT_TICKS, 8'($urandom_range(1, 6)));
				cfg_write(REG_DOOR_TICKS, 8'($urandom_range(1, 6)));
				cfg_write(REG_FLOOR_TICKS, 8'($urandom_range(1, 6)));
			end
			moved = 0;
			while (moved < PHASE_MOVES) begin
				beat = pick_beat();
				if (takes_effect(beat))
					moved++;
				push_beat(beat, (p % 4) == 2, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		settle();
		if (fault_count == 0 && pending_status.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
